// ===== sv/pulse_beat_detector_assert.svh =====
// Assertion macros for the pulse beat detector checker.
// Used by pbd_checker.sv; expects clk and rst in scope.
`ifndef PULSE_BEAT_DETECTOR_ASSERT_SVH
`define PULSE_BEAT_DETECTOR_ASSERT_SVH

// Checked outside reset only
`define PBD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every edge, reset included
`define PBD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/pbd_pkg.sv =====
// Shared types and constants of the pulse beat detector.
// No dependencies; imported by every module of the block.
package pbd_pkg;

  // Detector phases, as reported on phase_now
  typedef enum logic [2:0] {
    PH_INIT   = 3'd0,
    PH_WAIT   = 3'd1,
    PH_FOLLOW = 3'd2,
    PH_MAYBE  = 3'd3,
    PH_MASK   = 3'd4
  } phase_t;

  // Sequencer states of the core
  typedef enum logic [2:0] {
    CS_IDLE,
    CS_EVAL,
    CS_DIV10,
    CS_PEAK,
    CS_PCT,
    CS_PERIOD,
    CS_RATE,
    CS_DONE
  } core_state_t;

  // Configuration port
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_MIN_THRESHOLD    = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_THRESHOLD    = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DROP_MARGIN      = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_START_HOLDOFF_MS = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MASK_HOLDOFF_MS  = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_STALE_DELAY_MS   = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_INTERVAL_MS  = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_INTERVAL_MS  = 4'd7;

  localparam logic [14:0] RST_MIN_THRESHOLD    = 15'd40;
  localparam logic [14:0] RST_MAX_THRESHOLD    = 15'd800;
  localparam logic [14:0] RST_DROP_MARGIN      = 15'd100;
  localparam logic [15:0] RST_START_HOLDOFF_MS = 16'd2000;
  localparam logic [15:0] RST_MASK_HOLDOFF_MS  = 16'd400;
  localparam logic [15:0] RST_STALE_DELAY_MS   = 16'd2500;
  localparam logic [15:0] RST_MIN_INTERVAL_MS  = 16'd500;
  localparam logic [15:0] RST_MAX_INTERVAL_MS  = 16'd1500;

  // Serial divider sizing
  localparam int DIV_NUM_W = 22;
  localparam int DIV_DEN_W = 16;
  localparam int DIV_CNT_W = $clog2(DIV_NUM_W);

  // Arithmetic constants
  localparam logic [DIV_DEN_W-1:0] SAMPLE_MS  = 16'd10;
  localparam logic [DIV_DEN_W-1:0] DECAY_DEN  = 16'd100;
  localparam logic [DIV_DEN_W-1:0] PERIOD_DEN = 16'd10;
  localparam logic [DIV_NUM_W-1:0] DECAY_MUL  = 22'd99;
  localparam logic [DIV_NUM_W-1:0] PEAK_GAIN  = 22'd7;
  localparam logic [DIV_NUM_W-1:0] PERIOD_NEW = 22'd6;
  localparam logic [DIV_NUM_W-1:0] PERIOD_OLD = 22'd4;
  localparam logic [15:0]          MS_PER_MIN = 16'd60000;
  localparam int                   RATE_SHIFT = 3;

  typedef struct packed {
    logic              kind;
    logic signed [15:0] sample;
    logic [31:0]       now_ms;
  } in_item_t;

  typedef struct packed {
    logic        beat;
    logic [15:0] rate_bpm;
    logic [2:0]  phase_now;
    logic [14:0] threshold_now;
  } out_item_t;

  typedef struct packed {
    logic [14:0] min_threshold;
    logic [14:0] max_threshold;
    logic [14:0] drop_margin;
    logic [15:0] start_holdoff_ms;
    logic [15:0] mask_holdoff_ms;
    logic [15:0] stale_delay_ms;
    logic [15:0] min_interval_ms;
    logic [15:0] max_interval_ms;
  } cfg_regs_t;

  typedef struct packed {
    logic                 go;
    logic [DIV_NUM_W-1:0] num;
    logic [DIV_DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [DIV_NUM_W-1:0] quo;
  } div_rsp_t;

endpackage

// ===== sv/pbd_div.sv =====
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on pbd_pkg for the request and response structs.
module pbd_div
  import pbd_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam logic [DIV_CNT_W-1:0] CNT_LAST = DIV_CNT_W'(DIV_NUM_W - 1);

  logic                 busy;
  logic                 done;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DIV_DEN_W-1:0] rem;
  logic [DIV_DEN_W-1:0] den;
  logic [DIV_NUM_W-1:0] qsh;

  logic [DIV_DEN_W:0]   rem_sh;
  logic [DIV_DEN_W+1:0] diff;
  logic                 qbit;
  logic [DIV_DEN_W-1:0] rem_next;

  // One restoring step: shift in the next dividend bit, try the subtract
  always_comb begin
    rem_sh = {rem, qsh[DIV_NUM_W-1]};
    diff   = {1'b0, rem_sh} - {2'b00, den};
    qbit   = ~diff[DIV_DEN_W+1];
    if (qbit) begin
      rem_next = diff[DIV_DEN_W-1:0];
    end else begin
      rem_next = rem_sh[DIV_DEN_W-1:0];
    end
  end

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.go) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: dividend shifts out at the top as quotient bits shift in
  always_ff @(posedge clk) begin
    if (req.go) begin
      qsh <= req.num;
      den <= req.den;
      rem <= '0;
    end else if (busy) begin
      qsh <= {qsh[DIV_NUM_W-2:0], qbit};
      rem <= rem_next;
    end
  end

  assign rsp.done = done;
  assign rsp.quo  = qsh;

endmodule

// ===== sv/pbd_core.sv =====
// Detector sequencer: phase machine, threshold tracking and rate smoothing.
// Depends on pbd_pkg; instantiates the shared serial divider pbd_div.
module pbd_core
  import pbd_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  cfg_regs_t cfg,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      res_valid,
  input  logic      res_ready,
  output out_item_t res
);

  core_state_t state, state_next;

  // Architectural state
  phase_t      phase, phase_next;
  logic [14:0] level, level_next;
  logic [14:0] last_peak, last_peak_next;
  logic [31:0] last_beat_time, last_beat_time_next;
  logic [15:0] smoothed_period, smoothed_period_next;
  logic [15:0] smoothed_rate, smoothed_rate_next;
  logic        beat, beat_next;
  in_item_t    item, item_next;
  div_req_t    div_req, div_req_next;
  div_rsp_t    div_rsp;

  // Decision terms
  logic [31:0]        since;
  logic [15:0]        since16;
  logic signed [17:0] s18, lvl18, max18, min18, drop18, quo18, diff18;
  logic               samp_above, samp_below, drop_hit, in_window, stale;
  logic [14:0]        rise_lvl;
  logic [14:0]        dec_lvl, dec_lp;
  logic [15:0]        dec_sp;
  logic               use_peak;
  logic [12:0]        tenths;
  logic [18:0]        rate_sum;

  pbd_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // Comparisons on the latched item
  always_comb begin
    since      = item.now_ms - last_beat_time;
    since16    = since[15:0];
    s18        = {{2{item.sample[15]}}, item.sample};
    lvl18      = {3'b000, level};
    max18      = {3'b000, cfg.max_threshold};
    min18      = {3'b000, cfg.min_threshold};
    drop18     = {3'b000, cfg.drop_margin};
    samp_above = s18 > lvl18;
    samp_below = s18 < lvl18;
    drop_hit   = (s18 + drop18) < lvl18;
    in_window  = (since >= {16'h0000, cfg.min_interval_ms}) &&
                 (since <= {16'h0000, cfg.max_interval_ms});
    stale      = since > {16'h0000, cfg.stale_delay_ms};
    rise_lvl   = (s18 > max18) ? cfg.max_threshold : item.sample[14:0];
    // Waiting raises and clears stale history before the decay
    if (phase == PH_WAIT) begin
      dec_lvl = samp_above ? rise_lvl : level;
      dec_lp  = stale ? 15'd0 : last_peak;
      dec_sp  = stale ? 16'd0 : smoothed_period;
    end else begin
      dec_lvl = level;
      dec_lp  = last_peak;
      dec_sp  = smoothed_period;
    end
    use_peak = (dec_lp != 15'd0) && (dec_sp != 16'd0);
    // Divider results
    tenths   = div_rsp.quo[12:0];
    quo18    = {1'b0, div_rsp.quo[16:0]};
    diff18   = lvl18 - quo18;
    rate_sum = ({3'b000, smoothed_rate} << RATE_SHIFT) - {3'b000, smoothed_rate}
               + {3'b000, div_rsp.quo[15:0]};
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      CS_IDLE: begin
        if (in_valid) begin
          state_next = CS_EVAL;
        end
      end
      CS_EVAL: begin
        state_next = CS_DONE;
        if (!item.kind) begin
          unique case (phase)
            PH_WAIT, PH_MASK: begin
              state_next = use_peak ? CS_DIV10 : CS_PCT;
            end
            PH_MAYBE: begin
              if (drop_hit && in_window) begin
                if (smoothed_period != 16'd0) begin
                  state_next = CS_PERIOD;
                end else if (since16 != 16'd0) begin
                  state_next = CS_RATE;
                end
              end
            end
            default: state_next = CS_DONE;
          endcase
        end
      end
      CS_DIV10: begin
        if (div_rsp.done) begin
          state_next = CS_PEAK;
        end
      end
      CS_PEAK, CS_PCT, CS_RATE: begin
        if (div_rsp.done) begin
          state_next = CS_DONE;
        end
      end
      CS_PERIOD: begin
        if (div_rsp.done) begin
          state_next = (div_rsp.quo[15:0] == 16'd0) ? CS_DONE : CS_RATE;
        end
      end
      CS_DONE: begin
        if (res_ready) begin
          state_next = CS_IDLE;
        end
      end
      default: state_next = CS_IDLE;
    endcase
  end

  // Datapath updates
  always_comb begin
    phase_next           = phase;
    level_next           = level;
    last_peak_next       = last_peak;
    last_beat_time_next  = last_beat_time;
    smoothed_period_next = smoothed_period;
    smoothed_rate_next   = smoothed_rate;
    beat_next            = beat;
    item_next            = item;
    div_req_next         = '{go: 1'b0, num: div_req.num, den: div_req.den};
    unique case (state)
      CS_IDLE: begin
        if (in_valid) begin
          item_next = in_data;
          beat_next = 1'b0;
        end
      end
      CS_EVAL: begin
        if (item.kind) begin
          phase_next           = PH_INIT;
          level_next           = cfg.min_threshold;
          last_peak_next       = '0;
          last_beat_time_next  = '0;
          smoothed_period_next = '0;
          smoothed_rate_next   = '0;
        end else begin
          unique case (phase)
            PH_INIT: begin
              if (item.now_ms > {16'h0000, cfg.start_holdoff_ms}) begin
                phase_next = PH_WAIT;
              end
            end
            PH_WAIT, PH_MASK: begin
              if (phase == PH_WAIT) begin
                if (samp_above) begin
                  phase_next = PH_FOLLOW;
                end
                if (stale) begin
                  smoothed_rate_next = '0;
                end
              end else if (since > {16'h0000, cfg.mask_holdoff_ms}) begin
                phase_next = PH_WAIT;
              end
              level_next           = dec_lvl;
              last_peak_next       = dec_lp;
              smoothed_period_next = dec_sp;
              div_req_next.go      = 1'b1;
              if (use_peak) begin
                div_req_next.num = DIV_NUM_W'(dec_sp);
                div_req_next.den = SAMPLE_MS;
              end else begin
                div_req_next.num = DIV_NUM_W'(dec_lvl) * DECAY_MUL;
                div_req_next.den = DECAY_DEN;
              end
            end
            PH_FOLLOW: begin
              if (samp_below) begin
                phase_next = PH_MAYBE;
              end else begin
                level_next = rise_lvl;
              end
            end
            PH_MAYBE: begin
              if (drop_hit) begin
                beat_next           = 1'b1;
                last_peak_next      = level;
                phase_next          = PH_MASK;
                last_beat_time_next = item.now_ms;
                if (in_window) begin
                  if (smoothed_period == 16'd0) begin
                    smoothed_period_next = since16;
                    div_req_next.go      = (since16 != 16'd0);
                    div_req_next.num     = DIV_NUM_W'(MS_PER_MIN);
                    div_req_next.den     = since16;
                  end else begin
                    div_req_next.go  = 1'b1;
                    div_req_next.num = DIV_NUM_W'(since16) * PERIOD_NEW +
                                       DIV_NUM_W'(smoothed_period) * PERIOD_OLD;
                    div_req_next.den = PERIOD_DEN;
                  end
                end
              end else begin
                phase_next = PH_FOLLOW;
              end
            end
            default: begin
              // unknown phase code acts as a restart
              phase_next           = PH_INIT;
              level_next           = cfg.min_threshold;
              last_peak_next       = '0;
              last_beat_time_next  = '0;
              smoothed_period_next = '0;
              smoothed_rate_next   = '0;
            end
          endcase
        end
      end
      CS_DIV10: begin
        // divisor is max(period / 10, 1) * 10
        if (div_rsp.done) begin
          div_req_next.go  = 1'b1;
          div_req_next.num = DIV_NUM_W'(last_peak) * PEAK_GAIN;
          if (tenths == 13'd0) begin
            div_req_next.den = SAMPLE_MS;
          end else begin
            div_req_next.den = DIV_DEN_W'(tenths) * SAMPLE_MS;
          end
        end
      end
      CS_PEAK: begin
        if (div_rsp.done) begin
          level_next = (diff18 < min18) ? cfg.min_threshold : diff18[14:0];
        end
      end
      CS_PCT: begin
        if (div_rsp.done) begin
          level_next = (div_rsp.quo[14:0] < cfg.min_threshold) ?
                       cfg.min_threshold : div_rsp.quo[14:0];
        end
      end
      CS_PERIOD: begin
        if (div_rsp.done) begin
          smoothed_period_next = div_rsp.quo[15:0];
          div_req_next.go      = (div_rsp.quo[15:0] != 16'd0);
          div_req_next.num     = DIV_NUM_W'(MS_PER_MIN);
          div_req_next.den     = div_rsp.quo[15:0];
        end
      end
      CS_RATE: begin
        if (div_rsp.done) begin
          if (smoothed_rate == 16'd0) begin
            smoothed_rate_next = div_rsp.quo[15:0];
          end else begin
            smoothed_rate_next = rate_sum[18:RATE_SHIFT];
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Handshake and result outputs
  always_comb begin
    in_ready          = (state == CS_IDLE);
    res_valid         = (state == CS_DONE);
    res.beat          = beat;
    res.rate_bpm      = smoothed_rate;
    res.phase_now     = phase;
    res.threshold_now = level;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= CS_IDLE;
      div_req         <= '0;
      phase           <= PH_INIT;
      level           <= RST_MIN_THRESHOLD;
      last_peak       <= '0;
      last_beat_time  <= '0;
      smoothed_period <= '0;
      smoothed_rate   <= '0;
      beat            <= 1'b0;
    end else begin
      state           <= state_next;
      div_req         <= div_req_next;
      phase           <= phase_next;
      level           <= level_next;
      last_peak       <= last_peak_next;
      last_beat_time  <= last_beat_time_next;
      smoothed_period <= smoothed_period_next;
      smoothed_rate   <= smoothed_rate_next;
      beat            <= beat_next;
    end
  end

  // Payload register
  always_ff @(posedge clk) begin
    item <= item_next;
  end

endmodule

// ===== sv/pulse_beat_detector.sv =====
// Pulse beat detector, top level: configuration registers, output register
// and the detector core. Depends on pbd_pkg; instantiates pbd_core.
//
// Usage:
//   in channel  : one transaction per item, a filtered sample with its ms
//                 timestamp (kind = 0) or a restart (kind = 1).
//   out channel : exactly one result transaction per input item, in order:
//                 beat flag, smoothed rate, phase and threshold after the item.
//   cfg channel : register index and data; always ready. The user must write
//                 only while the block is idle; the block does not enforce it.
// Sequencing: items that need no division go from the evaluation state to
//   the done state and into the output register; items that decay the
//   threshold or update the rate run one or two divisions on the shared
//   bit-serial divider, 22 quotient bits each, between those two states.
// Throughput: one item at a time; the next item is taken as soon as the
//   previous result sits in the output register.
// Reset: registers return to their documented defaults, detector goes to
//   the init phase with the threshold at the minimum.
// Stall: a result held by out_ready stays in the output register; the core
//   finishes the following item and then waits until the register frees up.
module pulse_beat_detector
  import pbd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_regs_t cfg;
  logic      res_valid;
  logic      res_ready;
  out_item_t res;

  assign cfg_ready = 1'b1;

  // Configuration register file
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_threshold    <= RST_MIN_THRESHOLD;
      cfg.max_threshold    <= RST_MAX_THRESHOLD;
      cfg.drop_margin      <= RST_DROP_MARGIN;
      cfg.start_holdoff_ms <= RST_START_HOLDOFF_MS;
      cfg.mask_holdoff_ms  <= RST_MASK_HOLDOFF_MS;
      cfg.stale_delay_ms   <= RST_STALE_DELAY_MS;
      cfg.min_interval_ms  <= RST_MIN_INTERVAL_MS;
      cfg.max_interval_ms  <= RST_MAX_INTERVAL_MS;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_MIN_THRESHOLD:    cfg.min_threshold    <= cfg_data[14:0];
        REG_MAX_THRESHOLD:    cfg.max_threshold    <= cfg_data[14:0];
        REG_DROP_MARGIN:      cfg.drop_margin      <= cfg_data[14:0];
        REG_START_HOLDOFF_MS: cfg.start_holdoff_ms <= cfg_data;
        REG_MASK_HOLDOFF_MS:  cfg.mask_holdoff_ms  <= cfg_data;
        REG_STALE_DELAY_MS:   cfg.stale_delay_ms   <= cfg_data;
        REG_MIN_INTERVAL_MS:  cfg.min_interval_ms  <= cfg_data;
        REG_MAX_INTERVAL_MS:  cfg.max_interval_ms  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  pbd_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // Output register separates the core from the receiver
  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_data <= res;
    end
  end

endmodule

// ===== sv/pbd_checker.sv =====
// Port-level checks for the pulse beat detector, bound to the top level.
// Depends on pbd_pkg and pulse_beat_detector_assert.svh.
`include "pulse_beat_detector_assert.svh"

module pbd_checker
  import pbd_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  // A stalled result holds
  `PBD_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_data), "result changed while stalled")

  // Every item passes through the evaluation state before the next is taken
  `PBD_ASSERT(a_busy_after_take, in_valid && in_ready |=> !in_ready, "input taken on back-to-back cycles")

  // A confirmed beat always enters the refractory phase
  `PBD_ASSERT(a_beat_masks, out_valid && out_data.beat |-> out_data.phase_now == PH_MASK, "beat without masking phase")

  // Rate cannot exceed 60000 bpm
  `PBD_ASSERT(a_rate_range, out_valid |-> out_data.rate_bpm <= MS_PER_MIN, "rate out of range")

  // Reset empties the output register
  `PBD_ASSERT_ALWAYS(a_rst_clears, rst |=> !out_valid, "output valid after reset")

endmodule

bind pulse_beat_detector pbd_checker u_pbd_checker (.*);
